FILE: rtl/fern_forest_posterior_train_macros.svh
// assertion macros for the fern forest top level
// no dependencies
`ifndef FERN_FOREST_POSTERIOR_TRAIN_MACROS_SVH
`define FERN_FOREST_POSTERIOR_TRAIN_MACROS_SVH
`define FFP_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define FFP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: rtl/ffpt_pkg.sv
// shared constants and state codes for the fern forest
// no dependencies
`timescale 1ns / 1ps
package ffpt_pkg;
    localparam int VOTE_W = 19;
    localparam logic [VOTE_W-1:0] VOTE_MAX = '1;
    localparam logic [16:0] Q_ONE = 17'd32768;
    localparam logic [15:0] Q_HALF = 16'd16384;
    localparam logic [3:0] TREE_COUNT_RST = 4'd10;
    localparam logic [15:0] THRESH_RST = 16'd16384;
    localparam logic [0:0] REG_TREE_COUNT = 1'b0;
    localparam logic [0:0] REG_THRESH = 1'b1;
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_TRD   = 3'd3;
    localparam logic [2:0] S_TDIV  = 3'd4;
    localparam logic [2:0] S_TWR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
endpackage

FILE: rtl/fern_forest_posterior_train.sv
// fern forest top level: posterior voting with online training
// depends on ffpt_pkg and fern_forest_posterior_train_macros.svh
//
// usage: one leaf beat per tree on s_axis, tree 0 first, tlast on the final
// leaf. tuser carries {label, mode} (mode bit 0), tdata the leaf code.
// each leaf is a table read at the accepting edge, then the accumulate in
// S_ACC. without training m_axis tvalid rises from S_OUT, after the last
// leaf is accumulated; tdata carries vote_sum, tuser updated.
// when training, each stored tree adds a counter read, a 17-step
// restoring divider for the new posterior, and write back.
// after reset a clearing pass over the MAX_FERNS << LEAF_BITS entries zeroes
// the count and posterior table; s_axis tready stays low meanwhile, the apb
// port is served throughout. a stalled m_axis holds the result in its
// output register; leaves are still taken, and the next result waits until
// that register is free.
// apb: tree_count at 0x0, fern_threshold at 0x4; pready is always high.
`timescale 1ns / 1ps
`include "fern_forest_posterior_train_macros.svh"
module fern_forest_posterior_train
    import ffpt_pkg::*;
#(
    parameter int MAX_FERNS  = 10,
    parameter int LEAF_BITS  = 13,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // leaf[12:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // {label, mode}
    input  logic        s_axis_tlast,   // last_leaf
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // vote_sum[18:0], zero pad
    output logic        m_axis_tuser,   // updated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int TB = (MAX_FERNS > 1) ? $clog2(MAX_FERNS) : 1;
    localparam int PB = $clog2(MAX_FERNS + 1);
    localparam int AB = TB + LEAF_BITS;
    localparam int DEPTH = MAX_FERNS << LEAF_BITS;
    localparam int MW = 2 * COUNT_BITS + 16;
    localparam int RW = COUNT_BITS + 18;
    localparam int DIV_LAST = 19;
    localparam int SB = $clog2(DIV_LAST + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    // entry: {negative count, positive count, posterior}
    logic [MW-1:0]         m_tab [DEPTH];
    logic [LEAF_BITS-1:0]  r_leafbuf [MAX_FERNS];

    logic [2:0]            r_state, n_state;
    logic [AB-1:0]         r_clr;
    logic [3:0]            r_tree_count;
    logic [15:0]           r_thresh;
    logic [PB-1:0]         r_pos_cnt;
    logic [TB-1:0]         r_t;
    logic [VOTE_W-1:0]     r_vote;
    logic                  r_mode, r_label, r_last, r_upd;
    logic [AB-1:0]         r_addr;
    logic [MW-1:0]         r_rd;
    logic [COUNT_BITS-1:0] r_p, r_q;
    logic [RW-1:0]         r_rem;
    logic [COUNT_BITS:0]   r_den;
    logic [15:0]           r_quo;
    logic [SB-1:0]         r_step;
    logic                  r_ovalid, r_oupd;
    logic [VOTE_W-1:0]     r_ovote;

    logic [PB-1:0]         w_n;
    logic                  w_s_acc, w_wr, w_train;
    logic [VOTE_W:0]       w_sum;
    logic [VOTE_W-1:0]     w_v;
    logic [RW-1:0]         w_dsh, w_rem_sub;
    logic [19:0]           w_thr_n;
    logic [19:0]           w_half_n;
    logic [AB-1:0]         w_rd_addr;
    logic [15:0]           w_post_rd;
    logic [COUNT_BITS-1:0] w_p_rd, w_q_rd, w_p_new, w_q_new;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_THRESH) ? {16'd0, r_thresh} : {28'd0, r_tree_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_count <= TREE_COUNT_RST;
            r_thresh <= THRESH_RST;
        end else if (w_wr) begin
            if (paddr[2] == REG_TREE_COUNT) r_tree_count <= pwdata[3:0];
            else r_thresh <= pwdata[15:0];
        end
    end

    always_comb begin
        if (r_tree_count == 4'd0) w_n = PB'(1);
        else if (32'(r_tree_count) > MAX_FERNS) w_n = PB'(MAX_FERNS);
        else w_n = PB'(r_tree_count);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_post_rd = r_rd[15:0];
    assign w_p_rd = r_rd[16 +: COUNT_BITS];
    assign w_q_rd = r_rd[16+COUNT_BITS +: COUNT_BITS];
    assign w_p_new = (r_label && w_p_rd != CMAX) ? w_p_rd + COUNT_BITS'(1) : w_p_rd;
    assign w_q_new = (!r_label && w_q_rd != CMAX) ? w_q_rd + COUNT_BITS'(1) : w_q_rd;
    assign w_sum = {1'b0, r_vote} + {{(VOTE_W-16+1){1'b0}}, w_post_rd};
    assign w_v = !r_upd ? r_vote : (w_sum[VOTE_W] ? VOTE_MAX : w_sum[VOTE_W-1:0]);
    assign w_thr_n = 20'(r_thresh) * 20'(w_n);
    assign w_half_n = 20'(Q_HALF) * 20'(w_n);
    assign w_train = r_mode && (r_label ? (20'(w_v) <= w_thr_n) : (20'(w_v) >= w_half_n));
    assign w_dsh = RW'({r_den, 16'd0});
    assign w_rem_sub = r_rem - w_dsh;
    assign w_rd_addr = (r_state == S_IDLE) ?
        {r_pos_cnt[TB-1:0], s_axis_tdata[LEAF_BITS-1:0]} : r_addr;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (32'(r_clr) == DEPTH - 1) n_state = S_IDLE;
            S_IDLE:  if (w_s_acc) n_state = S_ACC;
            S_ACC: begin
                if (!r_last) n_state = S_IDLE;
                else if (w_train && r_pos_cnt != '0) n_state = S_TRD;
                else n_state = S_OUT;
            end
            S_TRD:   n_state = S_TDIV;
            S_TDIV:  if (32'(r_step) == DIV_LAST) n_state = S_TWR;
            S_TWR:   n_state = (PB'(r_t) + PB'(1) == r_pos_cnt) ? S_OUT : S_TRD;
            S_OUT:   if (!r_ovalid) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_pos_cnt <= '0;
            r_vote <= '0;
            r_ovalid <= 1'b0;
            r_last <= 1'b0;
            r_upd <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AB'(1);
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_s_acc) begin
                    r_mode <= s_axis_tuser[0];
                    r_label <= s_axis_tuser[1];
                    r_last <= s_axis_tlast;
                    if (r_pos_cnt < w_n) begin
                        r_leafbuf[r_pos_cnt[TB-1:0]] <= s_axis_tdata[LEAF_BITS-1:0];
                        r_pos_cnt <= r_pos_cnt + PB'(1);
                        r_upd <= 1'b1;
                    end else begin
                        r_upd <= 1'b0;
                    end
                end
                S_ACC: ;
                default: ;
            endcase
            if (r_state == S_ACC) begin
                r_vote <= w_v;
                r_t <= '0;
                r_upd <= w_train;
            end
            if (r_state == S_TRD) begin
                r_addr <= {r_t, r_leafbuf[r_t]};
                r_step <= '0;
            end
            if (r_state == S_TDIV) begin
                r_step <= r_step + SB'(1);
                if (r_step == SB'(1)) begin
                    r_p <= w_p_new;
                    r_q <= w_q_new;
                    r_den <= {1'b0, w_p_new} + {1'b0, w_q_new};
                end else if (r_step == SB'(2)) begin
                    r_rem <= RW'({r_p, 15'd0}) + RW'(r_den[COUNT_BITS:1]);
                    r_quo <= '0;
                end else if (r_step > SB'(2)) begin
                    if (r_rem >= w_dsh) begin
                        r_rem <= {w_rem_sub[RW-2:0], 1'b0};
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[RW-2:0], 1'b0};
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                end
            end
            if (r_state == S_TWR) r_t <= r_t + TB'(1);
            if (r_state == S_OUT && !r_ovalid) begin
                r_ovalid <= 1'b1;
                r_oupd <= r_upd;
                r_ovote <= r_vote;
                r_vote <= '0;
                r_pos_cnt <= '0;
            end
        end
    end

    // count and posterior table, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            m_tab[r_clr] <= '0;
        end else if (r_state == S_TWR) begin
            m_tab[r_addr] <= {r_q, r_p, (r_p == '0) ? 16'd0 : r_quo};
        end
        r_rd <= m_tab[w_rd_addr];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'd0, r_ovote};
    assign m_axis_tuser = r_oupd;

    `FFP_ASSERT_IMPL(a_no_take_clear, i_clk, i_rst_n, r_state == S_CLEAR, !s_axis_tready)
    `FFP_ASSERT_IMPL(a_pos_bound, i_clk, i_rst_n, 1'b1, 32'(r_pos_cnt) <= MAX_FERNS)
    `FFP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule
